[design/i8gap_pkg.sv]
package i8gap_pkg;

   localparam int SAMPLE_W  = 8;
   localparam int SUM_W     = 16;
   localparam int COUNT_W   = 8;
   localparam int RECIP_W   = 15;
   localparam int PROD_W    = 32;
   localparam int AVG_W     = 8;
   localparam int CHAN_W    = 6;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   // Q15 product shift, then requantising shift with round-half-up
   localparam int Q_SHIFT   = 15;
   localparam int OUT_SHIFT = 6;
   localparam int ROUND_BIAS = 32;

   localparam logic [COUNT_W-1:0] PIXEL_COUNT_RESET = 8'd125;
   localparam logic [RECIP_W-1:0] RECIPROCAL_RESET  = 15'd16777;

   typedef enum logic [0:0] {
      REG_PIXEL_COUNT = 1'b0,
      REG_RECIPROCAL  = 1'b1
   } reg_index_type;

endpackage

[design/i8gap_ram.sv]
module i8gap_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  logic                                       clock,
   input  logic                                       we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                           wdata,
   input  logic                                       re,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                           rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // read returns the old contents on a same-address write
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

[design/int8_global_average_pool_core.sv]
// int8 global average pool.
// req_ carries one signed 8-bit activation per beat, pixel-major with the
// channel index running fastest; the block keeps its own channel and pixel
// position, so no framing travels with the samples. Each channel's running
// 16-bit sum lives in a RAM; on the last pixel of a frame every sample closes
// its channel, and one beat per channel leaves on rsp_ with the requantised
// mean, the channel number and last on the final channel of the frame.
// A sample is taken every cycle while req_stall is low. Three register
// stages stand between the two sides: sum RAM read, accumulate and
// multiply, requantise into the output register; rsp_valid rises once
// a closing sample has passed them in turn. Throughput is set by the single
// read-modify-write per beat on the sum RAM, one beat per unstalled cycle.
// While rsp_stall is high the output register holds its beat; samples that
// close no channel keep flowing, and req_stall rises only once a closing
// sample cannot move on.
// Reset clears the positions, marks every sum as zero through per-channel
// valid bits (no clearing pass) and restores pixel_count to 125 and
// reciprocal to 16777. Register writes on the APB port leave sums and
// positions alone.
module int8_global_average_pool_core
   import i8gap_pkg::*;
#(
   parameter int CHANNEL_COUNT = 64,
   parameter int MAX_PIXELS    = 128
) (
   input  logic                         clock,
   input  logic                         reset,

   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic signed [SAMPLE_W-1:0]   req_sample,

   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic signed [AVG_W-1:0]      rsp_average,
   output logic [CHAN_W-1:0]            rsp_channel,
   output logic                         rsp_last,

   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [CSR_ADDR_W-1:0]        paddr,
   input  logic [CSR_DATA_W-1:0]        pwdata,
   output logic [CSR_DATA_W-1:0]        prdata,
   output logic                         pready
);

   localparam int CH_W  = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;
   localparam int PIX_W = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
   localparam logic [CH_W-1:0] LAST_CH      = CH_W'(CHANNEL_COUNT - 1);
   localparam logic [8:0]      LAST_PIX_MAX = 9'(MAX_PIXELS - 1);

   // ---------------- configuration ----------------
   logic [COUNT_W-1:0] pixel_count_ff, pixel_count_in;
   logic [RECIP_W-1:0] reciprocal_ff, reciprocal_in;
   logic               csr_write;
   reg_index_type      csr_index;

   assign pready    = 1'b1;
   assign csr_write = psel & penable & pwrite & pready;
   assign csr_index = reg_index_type'(paddr[2]);

   always_comb begin
      pixel_count_in = pixel_count_ff;
      reciprocal_in  = reciprocal_ff;
      prdata         = '0;
      case (csr_index)
         REG_PIXEL_COUNT: begin
            prdata = CSR_DATA_W'(pixel_count_ff);
            if (csr_write) pixel_count_in = pwdata[COUNT_W-1:0];
         end
         REG_RECIPROCAL: begin
            prdata = CSR_DATA_W'(reciprocal_ff);
            if (csr_write) reciprocal_in = pwdata[RECIP_W-1:0];
         end
         default: begin
            prdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pixel_count_ff <= PIXEL_COUNT_RESET;
         reciprocal_ff  <= RECIPROCAL_RESET;
      end else begin
         pixel_count_ff <= pixel_count_in;
         reciprocal_ff  <= reciprocal_in;
      end
   end

   // ---------------- position tracking ----------------
   logic [CH_W-1:0]  ch_ff, ch_in;
   logic [PIX_W-1:0] pix_ff, pix_in;
   logic [8:0]       lim_raw, lim;
   logic             last_pix, last_ch;
   logic             accept;

   // zero count behaves as one, and the count is capped at MAX_PIXELS
   assign lim_raw  = (pixel_count_ff == '0) ? 9'd0 : {1'b0, pixel_count_ff} - 9'd1;
   assign lim      = (lim_raw > LAST_PIX_MAX) ? LAST_PIX_MAX : lim_raw;
   assign last_pix = 9'(pix_ff) >= lim;
   assign last_ch  = ch_ff == LAST_CH;
   assign accept   = req_valid & ~req_stall;

   always_comb begin
      ch_in  = ch_ff;
      pix_in = pix_ff;
      if (accept) begin
         if (last_ch) begin
            ch_in  = '0;
            pix_in = last_pix ? '0 : pix_ff + 1'b1;
         end else begin
            ch_in  = ch_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ch_ff  <= '0;
         pix_ff <= '0;
      end else begin
         ch_ff  <= ch_in;
         pix_ff <= pix_in;
      end
   end

   // ---------------- stage 1: accumulate and multiply ----------------
   logic                       s1_valid_ff, s1_valid_in;
   logic signed [SAMPLE_W-1:0] s1_sample_ff;
   logic [CH_W-1:0]            s1_ch_ff;
   logic                       s1_close_ff;
   logic                       s1_last_ff;
   logic                       s1_hit_ff;
   logic                       s1_fwd_ff;
   logic [SUM_W-1:0]           s1_fwd_data_ff;
   logic                       s1_hold, s1_adv;

   logic [SUM_W-1:0]           ram_rdata;
   logic [SUM_W-1:0]           sum_base, sum_new, sum_wdata;
   logic signed [PROD_W-1:0]   product;
   logic [CHANNEL_COUNT-1:0]   sum_valid_ff;

   logic                       s2_valid_ff, s2_valid_in;
   logic signed [PROD_W-1:0]   s2_prod_ff;
   logic [CH_W-1:0]            s2_ch_ff;
   logic                       s2_last_ff;
   logic                       s2_hold, s2_adv;

   logic                       rsp_valid_ff, rsp_valid_in;
   logic signed [AVG_W-1:0]    rsp_average_ff;
   logic [CHAN_W-1:0]          rsp_channel_ff;
   logic                       rsp_last_ff;
   logic                       out_hold;

   assign out_hold  = rsp_valid_ff & rsp_stall;
   assign s2_hold   = s2_valid_ff & out_hold;
   // only a closing beat needs room downstream
   assign s1_hold   = s1_valid_ff & s1_close_ff & s2_hold;
   assign s1_adv    = s1_valid_ff & ~s1_hold;
   assign s2_adv    = s2_valid_ff & ~s2_hold;
   assign req_stall = s1_hold;

   // back-to-back beats on the same channel (single channel) bypass the RAM
   assign sum_base  = s1_fwd_ff ? s1_fwd_data_ff : (s1_hit_ff ? ram_rdata : '0);
   assign sum_new   = sum_base + SUM_W'(s1_sample_ff);
   assign sum_wdata = s1_close_ff ? '0 : sum_new;
   assign product   = $signed(sum_new) * $signed({1'b0, reciprocal_ff});

   i8gap_ram #(
      .WIDTH (SUM_W),
      .DEPTH (CHANNEL_COUNT)
   ) u_sum_ram (
      .clock (clock),
      .we    (s1_adv),
      .waddr (s1_ch_ff),
      .wdata (sum_wdata),
      .re    (accept),
      .raddr (ch_ff),
      .rdata (ram_rdata)
   );

   assign s1_valid_in = accept | (s1_valid_ff & ~s1_adv);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         sum_valid_ff <= '0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         if (s1_adv) begin
            sum_valid_ff[s1_ch_ff] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_sample_ff   <= req_sample;
         s1_ch_ff       <= ch_ff;
         s1_close_ff    <= last_pix;
         s1_last_ff     <= last_ch;
         s1_hit_ff      <= sum_valid_ff[ch_ff];
         s1_fwd_ff      <= s1_adv & (s1_ch_ff == ch_ff);
         s1_fwd_data_ff <= sum_wdata;
      end
   end

   // ---------------- stage 2: requantise and saturate ----------------
   logic signed [16:0] q;
   logic signed [17:0] q_round;
   logic signed [11:0] r;
   logic signed [AVG_W-1:0] avg;
   logic [CH_W+CHAN_W-1:0]  ch_wide;

   assign q       = s2_prod_ff[PROD_W-1:Q_SHIFT];
   assign q_round = {q[16], q} + 18'(ROUND_BIAS);
   assign r       = q_round[17:OUT_SHIFT];
   assign ch_wide = {{CHAN_W{1'b0}}, s2_ch_ff};

   always_comb begin
      if (r > 12'sd127) begin
         avg = 8'sd127;
      end else if (r < -12'sd128) begin
         avg = -8'sd128;
      end else begin
         avg = r[AVG_W-1:0];
      end
   end

   assign s2_valid_in  = (s1_adv & s1_close_ff) | (s2_valid_ff & ~s2_adv);
   assign rsp_valid_in = s2_adv | out_hold;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff  <= s2_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv & s1_close_ff) begin
         s2_prod_ff <= product;
         s2_ch_ff   <= s1_ch_ff;
         s2_last_ff <= s1_last_ff;
      end
      if (s2_adv) begin
         rsp_average_ff <= avg;
         rsp_channel_ff <= ch_wide[CHAN_W-1:0];
         rsp_last_ff    <= s2_last_ff;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_average = rsp_average_ff;
   assign rsp_channel = rsp_channel_ff;
   assign rsp_last    = rsp_last_ff;

   // ---------------- checks ----------------
   assert property (@(posedge clock) disable iff (reset)
      accept && last_ch |=> ch_ff == '0)
      else $error("channel position did not wrap after the last channel");

   assert property (@(posedge clock) disable iff (reset)
      9'(pix_ff) <= LAST_PIX_MAX)
      else $error("pixel position beyond the largest frame");

   assert property (@(posedge clock) disable iff (reset)
      accept && s1_adv && (s1_ch_ff == ch_ff) |-> CHANNEL_COUNT == 1)
      else $error("sum bypass taken with more than one channel");

   assert property (@(posedge clock) disable iff (reset)
      s1_hold |-> s2_valid_ff && rsp_valid_ff)
      else $error("closing beat held with room downstream");

endmodule
